// ===== src/ppi_pkg.sv =====
// Shared types, constants and the sine table for the particle pool integrator.
`timescale 1ns / 1ps
package ppi_pkg;

  // Sine table geometry (power of two)
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);

  // Generator and fixed-point constants
  localparam logic [31:0]        LCG_MUL     = 32'd1664525;
  localparam logic [31:0]        LCG_ADD     = 32'd1013904223;
  localparam logic [18:0]        TWO_PI_Q16  = 19'd411775;
  localparam logic [31:0]        SPIN_BIAS   = 32'd524288;
  localparam logic [16:0]        ONE_Q16     = 17'd65536;
  localparam logic signed [30:0] GRAV_LIM    = 31'sd655360000;
  localparam logic [22:0]        DRAG_LIM    = 23'd6553600;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0]        SPEED_MAX   = 16'd10000;
  localparam logic [15:0]        LIFE_MIN    = 16'd3;
  localparam logic [15:0]        LIFE_MAX    = 16'd30720;
  localparam logic [15:0]        SIZE_MIN    = 16'd1;
  localparam logic [15:0]        SIZE_MAX    = 16'd64000;

  // Command codes
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_EMIT = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  // Register map, by word index
  typedef enum logic [2:0] {
    REG_LIVE_LIMIT = 3'd0,
    REG_GRAVITY_X  = 3'd1,
    REG_GRAVITY_Y  = 3'd2,
    REG_DRAG_RATE  = 3'd3,
    REG_LIFE_RANGE = 3'd4,
    REG_SPEED_RANGE = 3'd5,
    REG_SIZE_RANGE = 3'd6,
    REG_SEED       = 3'd7
  } reg_e;

  // One pool entry
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        age;
    logic [15:0]        life;
    logic [15:0]        size;
    logic [31:0]        rotation;
    logic signed [31:0] spin;
  } rec_t;

  // Status from the integrator back to the controller
  typedef struct packed {
    logic       done;
    logic [6:0] count;
  } tick_stat_t;

  typedef logic signed [17:0] sine_tab_t [SINE_TABLE_DEPTH];

  // sin(pi/2 * u / 2^30) in Q30 by a series to x^9
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    x   = (u * HALF_PI_Q30) >> 30;
    x2  = (x * x) >> 30;
    t   = x;
    sum = x;
    t   = ((t * x2) >> 30) / 64'd6;
    sum = sum - t;
    t   = ((t * x2) >> 30) / 64'd20;
    sum = sum + t;
    t   = ((t * x2) >> 30) / 64'd42;
    sum = sum - t;
    t   = ((t * x2) >> 30) / 64'd72;
    sum = sum + t;
    if (sum > 64'h4000_0000) sum = 64'h4000_0000;
    return sum;
  endfunction

  // Full-turn sine table in signed Q2.16 (18 bits), built at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [31:0] a;
    logic [63:0] u;
    logic [63:0] s;
    for (int p = 0; p < SINE_TABLE_DEPTH; p++) begin
      a = 32'(p) << (32 - SINE_BITS);
      u = {34'd0, a[29:0]};
      if (a[30]) u = 64'h4000_0000 - u;
      s = quarter_sine(u) >> 14;
      tab[p] = a[31] ? -$signed(18'(s)) : $signed(18'(s));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Clamp a wide signed value into 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fff_ffff;
    if (v < -40'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

endpackage

// ===== src/ppi_mem.sv =====
// Particle pool memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ppi_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output ppi_pkg::rec_t       rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  ppi_pkg::rec_t       wr_data_i
);

  ppi_pkg::rec_t mem_q [DEPTH];
  ppi_pkg::rec_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/ppi_spawn.sv =====
// Particle generator: random draws from the LCG and one new pool entry per run.
`timescale 1ns / 1ps
module ppi_spawn (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               seed_wr_i,
  input  logic [31:0]        seed_i,
  input  logic [31:0]        speed_rng_i,
  input  logic [31:0]        life_rng_i,
  input  logic [31:0]        size_rng_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  output logic               wr_en_o,
  output ppi_pkg::rec_t      wr_data_o
);

  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
  } range_t;

  typedef enum logic [2:0] {
    SP_IDLE, SP_ANGLE, SP_SPEED, SP_VEL, SP_SIZE, SP_ROT, SP_SPIN
  } sp_state_e;

  // Order the two halves and clamp them to the legal span
  function automatic range_t split_range(input logic [31:0] packed_i,
                                         input logic [15:0] lmin,
                                         input logic [15:0] lmax);
    range_t      r;
    logic [15:0] a;
    logic [15:0] b;
    a    = packed_i[15:0];
    b    = packed_i[31:16];
    r.lo = (a < b) ? a : b;
    r.hi = (a < b) ? b : a;
    if (r.lo < lmin) r.lo = lmin;
    if (r.lo > lmax) r.lo = lmax;
    if (r.hi < r.lo) r.hi = r.lo;
    if (r.hi > lmax) r.hi = lmax;
    return r;
  endfunction

  sp_state_e          state_q;
  logic [31:0]        lcg_q;
  logic [31:0]        lcg_next;
  logic [23:0]        rnd;
  logic               advance;
  logic signed [17:0] sin_q, cos_q;
  logic [31:0]        spd_q;
  logic signed [31:0] vx_q, vy_q;
  logic [15:0]        life_q, size_q;
  logic [31:0]        rot_q;

  range_t               spd_rng, life_rng, size_rng;
  logic [15:0]          spd_d, life_d, size_d;
  logic [39:0]          spd_prod, life_prod, size_prod;
  logic [42:0]          rot_prod;
  logic signed [50:0]   vx_prod, vy_prod;
  logic [SINE_IDX_W-1:0] ang_idx;
  localparam int SINE_IDX_W = ppi_pkg::SINE_BITS;

  assign lcg_next = lcg_q * ppi_pkg::LCG_MUL + ppi_pkg::LCG_ADD;
  assign rnd      = lcg_q[23:0];
  assign advance  = (state_q == SP_IDLE) ? start_i : (state_q != SP_SPIN);

  // Range picks and the scaling products used by the draw steps
  assign spd_rng   = split_range(speed_rng_i, 16'd0, ppi_pkg::SPEED_MAX);
  assign life_rng  = split_range(life_rng_i, ppi_pkg::LIFE_MIN, ppi_pkg::LIFE_MAX);
  assign size_rng  = split_range(size_rng_i, ppi_pkg::SIZE_MIN, ppi_pkg::SIZE_MAX);
  assign spd_d     = spd_rng.hi - spd_rng.lo;
  assign life_d    = life_rng.hi - life_rng.lo;
  assign size_d    = size_rng.hi - size_rng.lo;
  assign spd_prod  = 40'(spd_d) * 40'(rnd);
  assign life_prod = 40'(life_d) * 40'(rnd);
  assign size_prod = 40'(size_d) * 40'(rnd);
  assign rot_prod  = 43'(ppi_pkg::TWO_PI_Q16) * 43'(rnd);
  assign vx_prod   = cos_q * $signed({1'b0, spd_q});
  assign vy_prod   = sin_q * $signed({1'b0, spd_q});
  assign ang_idx   = rnd[23 -: SINE_IDX_W];

  // Draw sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SP_IDLE;
      lcg_q   <= 32'd1;
    end else begin
      if (seed_wr_i) lcg_q <= seed_i;
      else if (advance) lcg_q <= lcg_next;
      unique case (state_q)
        SP_IDLE: if (start_i) state_q <= SP_ANGLE;
        SP_ANGLE: begin
          sin_q   <= ppi_pkg::SINE_TAB[ang_idx];
          cos_q   <= ppi_pkg::SINE_TAB[SINE_IDX_W'(ang_idx +
                       SINE_IDX_W'(ppi_pkg::SINE_TABLE_DEPTH / 4))];
          state_q <= SP_SPEED;
        end
        SP_SPEED: begin
          spd_q   <= {spd_rng.lo, 16'd0} + spd_prod[39:8];
          state_q <= SP_VEL;
        end
        SP_VEL: begin
          vx_q    <= vx_prod[47:16];
          vy_q    <= vy_prod[47:16];
          life_q  <= life_rng.lo + life_prod[39:24];
          state_q <= SP_SIZE;
        end
        SP_SIZE: begin
          size_q  <= size_rng.lo + size_prod[39:24];
          state_q <= SP_ROT;
        end
        SP_ROT: begin
          rot_q   <= {13'd0, rot_prod[42:24]};
          state_q <= SP_SPIN;
        end
        SP_SPIN: state_q <= SP_IDLE;
        default: state_q <= SP_IDLE;
      endcase
    end
  end

  // New entry goes out in the spin step
  assign wr_en_o            = (state_q == SP_SPIN);
  assign wr_data_o.pos_x    = origin_x_i;
  assign wr_data_o.pos_y    = origin_y_i;
  assign wr_data_o.vel_x    = vx_q;
  assign wr_data_o.vel_y    = vy_q;
  assign wr_data_o.age      = 31'd0;
  assign wr_data_o.life     = life_q;
  assign wr_data_o.size     = size_q;
  assign wr_data_o.rotation = rot_q;
  assign wr_data_o.spin     = $signed({12'd0, rnd[23:4]} - ppi_pkg::SPIN_BIAS);

endmodule

// ===== src/ppi_tick.sv =====
// Integrator: sweeps the pool through a pipelined update and compacts survivors.
`timescale 1ns / 1ps
module ppi_tick #(
  parameter int AW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [19:0]          dt_i,
  input  logic [6:0]           count_i,
  input  logic signed [30:0]   gx_i,
  input  logic signed [30:0]   gy_i,
  input  logic [22:0]          drag_i,
  output logic                 rd_en_o,
  output logic [AW-1:0]        rd_addr_o,
  input  ppi_pkg::rec_t        rd_data_i,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output ppi_pkg::rec_t        wr_data_o,
  output ppi_pkg::tick_stat_t  stat_o
);

  typedef enum logic [1:0] {TK_IDLE, TK_MUL, TK_FAC, TK_RUN} tk_state_e;

  tk_state_e          state_q;
  logic [19:0]        dt_q;
  logic [6:0]         cnt_q, rd_idx_q, wr_idx_q;
  logic signed [51:0] gxdt_q, gydt_q;
  logic [42:0]        drdt_q;
  logic signed [35:0] gdx_q, gdy_q;
  logic [16:0]        fac_q;
  logic [26:0]        drag_dt;
  logic signed [20:0] dt_s;
  logic               v1_q, va_q, vb_q, vc_q;
  logic               sweep_done;

  // Stage registers
  ppi_pkg::rec_t      a_rec, b_rec, c_rec;
  logic [30:0]        a_age, b_age, c_age;
  logic signed [31:0] a_vx, a_vy, c_vx, c_vy;
  logic signed [52:0] a_rprod, c_pmx, c_pmy;
  logic signed [49:0] b_vxf, b_vyf;
  logic [31:0]        b_rot, c_rot;

  logic [31:0]        age_sum;
  logic               alive;

  assign dt_s       = $signed({1'b0, dt_q});
  assign drag_dt    = drdt_q[42:16];
  assign age_sum    = 32'(rd_data_i.age) + 32'(dt_q);
  assign rd_en_o    = (state_q == TK_RUN) && (rd_idx_q < cnt_q);
  assign rd_addr_o  = rd_idx_q[AW-1:0];
  assign sweep_done = (state_q == TK_RUN) && (rd_idx_q == cnt_q) &&
                      !v1_q && !va_q && !vb_q && !vc_q;
  assign alive      = c_age < {7'd0, c_rec.life, 8'd0};

  // Control: per-tick setup and sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= TK_IDLE;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      v1_q     <= 1'b0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      vc_q     <= 1'b0;
    end else begin
      v1_q <= rd_en_o;
      va_q <= v1_q;
      vb_q <= va_q;
      vc_q <= vb_q;
      unique case (state_q)
        TK_IDLE: if (start_i) begin
          dt_q     <= dt_i;
          cnt_q    <= count_i;
          rd_idx_q <= '0;
          wr_idx_q <= '0;
          state_q  <= TK_MUL;
        end
        TK_MUL: begin
          gxdt_q  <= gx_i * dt_s;
          gydt_q  <= gy_i * dt_s;
          drdt_q  <= 43'(drag_i) * 43'(dt_q);
          state_q <= TK_FAC;
        end
        TK_FAC: begin
          gdx_q   <= 36'(gxdt_q >>> 16);
          gdy_q   <= 36'(gydt_q >>> 16);
          fac_q   <= (drag_dt > 27'(ppi_pkg::ONE_Q16)) ? 17'd0 :
                     17'(27'(ppi_pkg::ONE_Q16) - drag_dt);
          state_q <= TK_RUN;
        end
        TK_RUN: begin
          if (rd_en_o) rd_idx_q <= rd_idx_q + 7'd1;
          if (wr_en_o) wr_idx_q <= wr_idx_q + 7'd1;
          if (sweep_done) state_q <= TK_IDLE;
        end
        default: state_q <= TK_IDLE;
      endcase
    end
  end

  // Stage A: age, gravity, spin product
  always_ff @(posedge clk_i) begin
    a_rec   <= rd_data_i;
    a_age   <= age_sum[31] ? 31'h7fff_ffff : age_sum[30:0];
    a_vx    <= ppi_pkg::sat32(40'(rd_data_i.vel_x) + 40'(gdx_q));
    a_vy    <= ppi_pkg::sat32(40'(rd_data_i.vel_y) + 40'(gdy_q));
    a_rprod <= rd_data_i.spin * dt_s;
  end

  // Stage B: drag factor, rotation wraps
  always_ff @(posedge clk_i) begin
    b_rec <= a_rec;
    b_age <= a_age;
    b_vxf <= a_vx * $signed({1'b0, fac_q});
    b_vyf <= a_vy * $signed({1'b0, fac_q});
    b_rot <= a_rec.rotation + 32'(a_rprod >>> 16);
  end

  // Stage C: displacement products
  always_ff @(posedge clk_i) begin
    c_rec <= b_rec;
    c_age <= b_age;
    c_rot <= b_rot;
    c_vx  <= 32'(b_vxf >>> 16);
    c_vy  <= 32'(b_vyf >>> 16);
    c_pmx <= $signed(32'(b_vxf >>> 16)) * dt_s;
    c_pmy <= $signed(32'(b_vyf >>> 16)) * dt_s;
  end

  // Stage D: move and write back survivors at the compacted slot
  assign wr_en_o            = vc_q && alive;
  assign wr_addr_o          = wr_idx_q[AW-1:0];
  assign wr_data_o.pos_x    = ppi_pkg::sat32(40'(c_rec.pos_x) + 40'(c_pmx >>> 16));
  assign wr_data_o.pos_y    = ppi_pkg::sat32(40'(c_rec.pos_y) + 40'(c_pmy >>> 16));
  assign wr_data_o.vel_x    = c_vx;
  assign wr_data_o.vel_y    = c_vy;
  assign wr_data_o.age      = c_age;
  assign wr_data_o.life     = c_rec.life;
  assign wr_data_o.size     = c_rec.size;
  assign wr_data_o.rotation = c_rot;
  assign wr_data_o.spin     = c_rec.spin;

  assign stat_o.done  = sweep_done;
  assign stat_o.count = wr_idx_q;

endmodule

// ===== src/particle_pool_integrator.sv =====
// Top level: register port, command sequencer, result register and pool memory.
`timescale 1ns / 1ps
// The pool sits in one synchronous memory and one item is handled at a time.
// A tick reads every live entry once through the memory's single read port
// into a four-stage update pipeline and writes survivors back packed toward
// slot 0. An emit runs the generator's six draw steps per new particle. A
// readout gives one beat per particle, a memory read then a capture into the
// result register, held while the receiver stalls. Tick, emit and unused
// commands give one status beat. Configuration must be written through the
// register port only while the block is idle; the block does not enforce
// this. Lowering live_limit drops the particles at and above the new limit.
module particle_pool_integrator #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [19:0]        delta_time_i,
  input  logic [6:0]         emit_count_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               has_particle_o,
  output logic               last_o,
  output logic [6:0]         live_count_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] rotation_o,
  output logic [15:0]        size_o,
  output logic [30:0]        age_o,
  output logic [15:0]        life_span_o
);

  localparam int         AW      = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam logic [6:0] MAX_CNT = 7'(MAX_PARTICLES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_TICK, ST_EMIT, ST_SPAWN, ST_RD_REQ, ST_RD_CAP, ST_STATUS
  } state_e;

  function automatic logic [6:0] eff_limit(input logic [6:0] l);
    if (l == 7'd0) return 7'd1;
    if (l > MAX_CNT) return MAX_CNT;
    return l;
  endfunction

  // Configuration registers
  logic [6:0]         live_limit_q;
  logic [30:0]        gravity_x_q, gravity_y_q;
  logic [22:0]        drag_q;
  logic [31:0]        life_rng_q, speed_rng_q, size_rng_q, seed_q;
  logic               cfg_wr;
  ppi_pkg::reg_e      reg_sel;

  // Sequencer state
  state_e             state_q;
  logic [6:0]         count_q, emitted_q, n_q, rd_idx_q;
  logic signed [31:0] ox_q, oy_q;
  logic [6:0]         lim;
  logic               in_acc, slot_free, spawn_start, tick_start;

  // Result register
  logic               out_valid_q, has_q, last_q;
  logic [6:0]         cnt_out_q;
  logic signed [31:0] px_q, py_q, rot_q;
  logic [15:0]        size_q, life_q;
  logic [30:0]        age_q;

  // Clamped physics settings
  logic signed [30:0] gx_c, gy_c;
  logic [22:0]        drag_c;

  // Memory ports and submodule links
  logic                mem_rd_en, mem_wr_en;
  logic [AW-1:0]       mem_rd_addr, mem_wr_addr;
  ppi_pkg::rec_t       mem_rd_data, mem_wr_data;
  logic                tk_rd_en, tk_wr_en, sp_wr_en;
  logic [AW-1:0]       tk_rd_addr, tk_wr_addr;
  ppi_pkg::rec_t       tk_wr_data, sp_wr_data;
  ppi_pkg::tick_stat_t tk_stat;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = ppi_pkg::reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_limit_q <= 7'd64;
      gravity_x_q  <= '0;
      gravity_y_q  <= '0;
      drag_q       <= '0;
      life_rng_q   <= 32'h0100_0100;
      speed_rng_q  <= '0;
      size_rng_q   <= 32'h0040_0040;
      seed_q       <= 32'd1;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ppi_pkg::REG_LIVE_LIMIT:  live_limit_q <= pwdata[6:0];
        ppi_pkg::REG_GRAVITY_X:   gravity_x_q  <= pwdata[30:0];
        ppi_pkg::REG_GRAVITY_Y:   gravity_y_q  <= pwdata[30:0];
        ppi_pkg::REG_DRAG_RATE:   drag_q       <= pwdata[22:0];
        ppi_pkg::REG_LIFE_RANGE:  life_rng_q   <= pwdata;
        ppi_pkg::REG_SPEED_RANGE: speed_rng_q  <= pwdata;
        ppi_pkg::REG_SIZE_RANGE:  size_rng_q   <= pwdata;
        ppi_pkg::REG_SEED:        seed_q       <= pwdata;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_sel)
      ppi_pkg::REG_LIVE_LIMIT:  prdata = {25'd0, live_limit_q};
      ppi_pkg::REG_GRAVITY_X:   prdata = {1'b0, gravity_x_q};
      ppi_pkg::REG_GRAVITY_Y:   prdata = {1'b0, gravity_y_q};
      ppi_pkg::REG_DRAG_RATE:   prdata = {9'd0, drag_q};
      ppi_pkg::REG_LIFE_RANGE:  prdata = life_rng_q;
      ppi_pkg::REG_SPEED_RANGE: prdata = speed_rng_q;
      ppi_pkg::REG_SIZE_RANGE:  prdata = size_rng_q;
      ppi_pkg::REG_SEED:        prdata = seed_q;
    endcase
  end

  // Clamp gravity and drag to their working spans
  always_comb begin
    gx_c = $signed(gravity_x_q);
    if (gx_c > ppi_pkg::GRAV_LIM) gx_c = ppi_pkg::GRAV_LIM;
    if (gx_c < -ppi_pkg::GRAV_LIM) gx_c = -ppi_pkg::GRAV_LIM;
    gy_c = $signed(gravity_y_q);
    if (gy_c > ppi_pkg::GRAV_LIM) gy_c = ppi_pkg::GRAV_LIM;
    if (gy_c < -ppi_pkg::GRAV_LIM) gy_c = -ppi_pkg::GRAV_LIM;
    drag_c = (drag_q > ppi_pkg::DRAG_LIM) ? ppi_pkg::DRAG_LIM : drag_q;
  end

  // Handshake terms
  assign lim         = eff_limit(live_limit_q);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign tick_start  = in_acc && (cmd_i == 2'(ppi_pkg::CMD_TICK));
  assign spawn_start = (state_q == ST_EMIT) && (emitted_q < n_q) && (count_q < lim);

  // Memory port steering
  assign mem_rd_en   = (state_q == ST_RD_REQ) || tk_rd_en;
  assign mem_rd_addr = (state_q == ST_RD_REQ) ? rd_idx_q[AW-1:0] : tk_rd_addr;
  assign mem_wr_en   = sp_wr_en || tk_wr_en;
  assign mem_wr_addr = sp_wr_en ? count_q[AW-1:0] : tk_wr_addr;
  assign mem_wr_data = sp_wr_en ? sp_wr_data : tk_wr_data;

  // Command sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      emitted_q   <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_wr && reg_sel == ppi_pkg::REG_LIVE_LIMIT &&
              count_q > eff_limit(pwdata[6:0])) begin
            count_q <= eff_limit(pwdata[6:0]);
          end
          if (in_acc) begin
            n_q  <= emit_count_i;
            ox_q <= origin_x_i;
            oy_q <= origin_y_i;
            unique case (ppi_pkg::cmd_e'(cmd_i))
              ppi_pkg::CMD_TICK: state_q <= ST_TICK;
              ppi_pkg::CMD_EMIT: begin
                emitted_q <= '0;
                state_q   <= ST_EMIT;
              end
              ppi_pkg::CMD_READ: begin
                rd_idx_q <= '0;
                state_q  <= (count_q == 7'd0) ? ST_STATUS : ST_RD_REQ;
              end
              default: state_q <= ST_STATUS;
            endcase
          end
        end
        ST_TICK: if (tk_stat.done) begin
          count_q <= tk_stat.count;
          state_q <= ST_STATUS;
        end
        ST_EMIT: state_q <= spawn_start ? ST_SPAWN : ST_STATUS;
        ST_SPAWN: if (sp_wr_en) begin
          count_q   <= count_q + 7'd1;
          emitted_q <= emitted_q + 7'd1;
          state_q   <= ST_EMIT;
        end
        ST_RD_REQ: state_q <= ST_RD_CAP;
        ST_RD_CAP: if (slot_free) begin
          out_valid_q <= 1'b1;
          has_q       <= 1'b1;
          last_q      <= (rd_idx_q + 7'd1 == count_q);
          cnt_out_q   <= count_q;
          px_q        <= mem_rd_data.pos_x;
          py_q        <= mem_rd_data.pos_y;
          rot_q       <= $signed(mem_rd_data.rotation);
          size_q      <= mem_rd_data.size;
          age_q       <= mem_rd_data.age;
          life_q      <= mem_rd_data.life;
          rd_idx_q    <= rd_idx_q + 7'd1;
          state_q     <= (rd_idx_q + 7'd1 == count_q) ? ST_IDLE : ST_RD_REQ;
        end
        ST_STATUS: if (slot_free) begin
          out_valid_q <= 1'b1;
          has_q       <= 1'b0;
          last_q      <= 1'b1;
          cnt_out_q   <= count_q;
          px_q        <= '0;
          py_q        <= '0;
          rot_q       <= '0;
          size_q      <= '0;
          age_q       <= '0;
          life_q      <= '0;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign has_particle_o = has_q;
  assign last_o         = last_q;
  assign live_count_o   = cnt_out_q;
  assign pos_x_o        = px_q;
  assign pos_y_o        = py_q;
  assign rotation_o     = rot_q;
  assign size_o         = size_q;
  assign age_o          = age_q;
  assign life_span_o    = life_q;

  ppi_mem #(
    .DEPTH(MAX_PARTICLES),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data)
  );

  ppi_spawn u_spawn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (spawn_start),
    .seed_wr_i  (cfg_wr && reg_sel == ppi_pkg::REG_SEED),
    .seed_i     (pwdata),
    .speed_rng_i(speed_rng_q),
    .life_rng_i (life_rng_q),
    .size_rng_i (size_rng_q),
    .origin_x_i (ox_q),
    .origin_y_i (oy_q),
    .wr_en_o    (sp_wr_en),
    .wr_data_o  (sp_wr_data)
  );

  ppi_tick #(
    .AW(AW)
  ) u_tick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (tick_start),
    .dt_i     (delta_time_i),
    .count_i  (count_q),
    .gx_i     (gx_c),
    .gy_i     (gy_c),
    .drag_i   (drag_c),
    .rd_en_o  (tk_rd_en),
    .rd_addr_o(tk_rd_addr),
    .rd_data_i(mem_rd_data),
    .wr_en_o  (tk_wr_en),
    .wr_addr_o(tk_wr_addr),
    .wr_data_o(tk_wr_data),
    .stat_o   (tk_stat)
  );

  // Pool never holds more than it has room for
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("live count above pool size");

  // Status beats always close their item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !has_q |-> last_q)
    else $error("status beat without last");

  // A tick can only shrink the pool
  a_tick_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK) && tk_stat.done |=> count_q <= $past(count_q))
    else $error("tick grew the pool");

  // A new particle is written only below the live limit
  a_spawn_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_wr_en |-> count_q < lim)
    else $error("spawn write beyond live limit");

endmodule
